### rtl/value_noise_2d_sampler_assert.svh
// Assertion macros for the noise sampler.
`ifndef VALUE_NOISE_2D_SAMPLER_ASSERT_SVH
`define VALUE_NOISE_2D_SAMPLER_ASSERT_SVH

// same-cycle implication
`define VN2D_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vn2d assertion failed");

// next-cycle implication
`define VN2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vn2d assertion failed");

`endif

### rtl/vn2d_pkg.sv
package vn2d_pkg;

  localparam int COORD_W    = 16;
  localparam int WEIGHT_W   = 16;
  localparam int HASH_W     = 32;
  localparam int NOISE_W    = 32;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int LAT_W  = COORD_W + 1;
  localparam int DIFF_W = HASH_W + 1;
  localparam int PRD_W  = DIFF_W + WEIGHT_W + 1;
  localparam int NST    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT = CFG_IDX_W'(1);

  localparam logic [HASH_W-1:0] HASH_COL  = HASH_W'(13);
  localparam logic [HASH_W-1:0] HASH_ROW  = HASH_W'(251);
  localparam int                HASH_XSH  = 17;
  localparam logic [HASH_W-1:0] HASH_MUL1 = HASH_W'(4643);
  localparam logic [HASH_W-1:0] HASH_ADD1 = HASH_W'(6047);
  localparam logic [HASH_W-1:0] HASH_MUL2 = HASH_W'(13921);
  localparam logic [HASH_W-1:0] HASH_ADD2 = HASH_W'(52543);
  localparam logic [HASH_W-1:0] HASH_MUL3 = HASH_W'(96053);
  localparam logic [HASH_W-1:0] HASH_SUB3 = HASH_W'(104711);

  localparam logic [WEIGHT_W+1:0] SMOOTH_3 = (WEIGHT_W + 2)'(3) << WEIGHT_W;
  localparam logic [HASH_W-1:0]   SIGN_FLIP = HASH_W'(1) << (HASH_W - 1);

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [LAT_W-1:0]    lat_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [HASH_W-1:0]   hash_t;

endpackage

### rtl/vn2d_if.sv
interface vn2d_pix_if import vn2d_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface vn2d_noise_if import vn2d_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

interface vn2d_cfg_if import vn2d_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/value_noise_2d_sampler.sv
// 2D value noise sampler, smoothstep-weighted bilinear blend of hashed lattice corners.
//
// pix_i   : one word per pixel (pixel_x, pixel_y), valid/ready.
// noise_o : one word per pixel (noise_value, signed Q1.31), valid/ready, in order.
// cfg_i   : register writes (index 0 seed, index 1 scale_shift), always ready.
//           Write only while no pixel is in flight.
//
// Ten register stages: axis split, hash seed/xor and f*f, four hash multiplies
// (smoothstep product alongside), y-blend product, y-blend add, x-blend product,
// x-blend add into the output register. noise_o.valid is the last stage's valid
// bit; one word per cycle is sustained while noise_o.ready is high.
// Each stage has its own valid bit and advances when it is empty or its
// successor advances, so bubbles close up under a stall. While noise_o is
// stalled, pix_i.ready stays high until all ten stages are full; nothing is
// dropped or repeated.
// Reset clears the stage valid bits, seed and scale_shift.
module value_noise_2d_sampler import vn2d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  vn2d_pix_if.sink           pix_i,
  vn2d_noise_if.source       noise_o,
  vn2d_cfg_if.sink           cfg_i
);

  `include "value_noise_2d_sampler_assert.svh"

  hash_t              seed_q;
  logic [SHIFT_W-1:0] shift_q;

  logic [NST:1] v_q;
  logic [NST:1] adv;

  lat_t    lo1_q [2];
  lat_t    hi1_q [2];
  weight_t f1_q  [2];
  lat_t    lo1_d [2];
  lat_t    hi1_d [2];
  weight_t f1_d  [2];

  hash_t   h_q [2:6][4];
  hash_t   h_d [2:6][4];
  weight_t sq2_q [2];
  weight_t sq2_d [2];
  weight_t f2_q  [2];
  weight_t t_q [3:6][2];
  weight_t t3_d [2];

  logic signed [PRD_W-1:0] prd7_q [2];
  logic signed [PRD_W-1:0] prd7_d [2];
  hash_t                   base7_q [2];
  weight_t                 tx7_q;
  hash_t                   col8_q [2];
  hash_t                   col8_d [2];
  weight_t                 tx8_q;
  logic signed [PRD_W-1:0] prd9_q;
  logic signed [PRD_W-1:0] prd9_d;
  hash_t                   base9_q;
  logic signed [NOISE_W-1:0] noise_q;
  logic signed [NOISE_W-1:0] noise_d;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      shift_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SEED:        seed_q  <= cfg_i.data[HASH_W-1:0];
        CFG_SCALE_SHIFT: shift_q <= cfg_i.data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  always_comb begin
    adv[NST] = !v_q[NST] || noise_o.ready;
    for (int k = NST - 1; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign pix_i.ready         = adv[1];
  assign noise_o.valid       = v_q[NST];
  assign noise_o.noise_value = noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= pix_i.valid;
      for (int k = 2; k <= NST; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // s1: lattice cell and weight per axis
  always_comb begin
    coord_t                      p;
    coord_t                      frac;
    logic [COORD_W+WEIGHT_W-1:0] fw;
    for (int a = 0; a < 2; a++) begin
      p        = (a == 0) ? pix_i.pixel_x : pix_i.pixel_y;
      frac     = p & ~({COORD_W{1'b1}} << shift_q);
      lo1_d[a] = LAT_W'(p >> shift_q);
      hi1_d[a] = lo1_d[a] + LAT_W'(frac != '0);
      fw       = {frac, WEIGHT_W'(0)} >> shift_q;
      f1_d[a]  = fw[WEIGHT_W-1:0];
    end
  end

  // s2..s6: corner hashes (lanes: left-top, left-bottom, right-top, right-bottom)
  always_comb begin
    hash_t                     h0;
    lat_t                      c;
    lat_t                      r;
    logic [2*WEIGHT_W-1:0]     sq;
    logic [WEIGHT_W+1:0]       m;
    logic [2*WEIGHT_W+1:0]     sm;
    for (int l = 0; l < 4; l++) begin
      c         = (l >= 2) ? hi1_q[0] : lo1_q[0];
      r         = (l % 2 == 1) ? hi1_q[1] : lo1_q[1];
      h0        = seed_q + HASH_W'(c) * HASH_COL + HASH_W'(r) * HASH_ROW;
      h_d[2][l] = h0 ^ (h0 << HASH_XSH);
      h_d[3][l] = h_q[2][l] * HASH_MUL1 + HASH_ADD1;
      h_d[4][l] = h_q[3][l] * HASH_MUL2 + HASH_ADD2;
      h_d[5][l] = h_q[4][l] * ~h_q[4][l];
      h_d[6][l] = h_q[5][l] * HASH_MUL3 - HASH_SUB3;
    end
    for (int a = 0; a < 2; a++) begin
      sq       = f1_q[a] * f1_q[a];
      sq2_d[a] = sq[2*WEIGHT_W-1:WEIGHT_W];
      m        = SMOOTH_3 - (WEIGHT_W + 2)'({f2_q[a], 1'b0});
      sm       = sq2_q[a] * m;
      t3_d[a]  = sm[2*WEIGHT_W-1:WEIGHT_W];
    end
  end

  // s7..s10: floor lerp a + ((b - a) * t) >>> WB, y first, then x
  always_comb begin
    logic signed [DIFF_W-1:0] d;
    logic signed [PRD_W-1:0]  sum;
    for (int k = 0; k < 2; k++) begin
      d         = $signed({1'b0, h_q[6][2*k+1]}) - $signed({1'b0, h_q[6][2*k]});
      prd7_d[k] = d * $signed({1'b0, t_q[6][1]});
      sum       = $signed({{(PRD_W-HASH_W){1'b0}}, base7_q[k]}) + (prd7_q[k] >>> WEIGHT_W);
      col8_d[k] = sum[HASH_W-1:0];
    end
    d       = $signed({1'b0, col8_q[1]}) - $signed({1'b0, col8_q[0]});
    prd9_d  = d * $signed({1'b0, tx8_q});
    sum     = $signed({{(PRD_W-HASH_W){1'b0}}, base9_q}) + (prd9_q >>> WEIGHT_W);
    noise_d = $signed(sum[HASH_W-1:0] ^ SIGN_FLIP);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      lo1_q <= lo1_d;
      hi1_q <= hi1_d;
      f1_q  <= f1_d;
    end
    if (adv[2]) begin
      h_q[2] <= h_d[2];
      sq2_q  <= sq2_d;
      f2_q   <= f1_q;
    end
    if (adv[3]) begin
      h_q[3] <= h_d[3];
      t_q[3] <= t3_d;
    end
    for (int k = 4; k <= 6; k++) begin
      if (adv[k]) begin
        h_q[k] <= h_d[k];
        t_q[k] <= t_q[k-1];
      end
    end
    if (adv[7]) begin
      prd7_q     <= prd7_d;
      base7_q[0] <= h_q[6][0];
      base7_q[1] <= h_q[6][2];
      tx7_q      <= t_q[6][0];
    end
    if (adv[8]) begin
      col8_q <= col8_d;
      tx8_q  <= tx7_q;
    end
    if (adv[9]) begin
      prd9_q  <= prd9_d;
      base9_q <= col8_q[0];
    end
    if (adv[10]) begin
      noise_q <= noise_d;
    end
  end

  `VN2D_ASSERT_IMPL(a_blocked_only_when_full, !pix_i.ready, &v_q)
  `VN2D_ASSERT_IMPL(a_x_cell_span, v_q[1], hi1_q[0] == lo1_q[0] || hi1_q[0] == lo1_q[0] + 1'b1)
  `VN2D_ASSERT_IMPL(a_y_cell_span, v_q[1], hi1_q[1] == lo1_q[1] || hi1_q[1] == lo1_q[1] + 1'b1)
  `VN2D_ASSERT_NEXT(a_accept_fills_s1, pix_i.valid && pix_i.ready, v_q[1])

endmodule

### sim/value_noise_2d_sampler_tb.sv
module value_noise_2d_sampler_tb;
  import vn2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 88;

  class noise_predictor;
    hash_t                     seed;
    logic [SHIFT_W-1:0]        shift;
    logic signed [NOISE_W-1:0] expected_noise[$];
    int unsigned               errors;

    function new();
      seed   = '0;
      shift  = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_SEED) begin
        seed = data[HASH_W-1:0];
      end else if (idx == CFG_SCALE_SHIFT) begin
        shift = data[SHIFT_W-1:0];
      end
    endfunction

    function hash_t corner(logic [31:0] c, logic [31:0] r);
      hash_t h;
      h = seed + HASH_COL * c + HASH_ROW * r;
      h = (h << HASH_XSH) ^ h;
      h = h * HASH_MUL1 + HASH_ADD1;
      h = h * HASH_MUL2 + HASH_ADD2;
      h = h * (32'hFFFF_FFFF - h) * HASH_MUL3 - HASH_SUB3;
      return h;
    endfunction

    function logic [63:0] smooth(logic [63:0] f);
      logic [63:0] sq;
      logic [63:0] m;
      sq = (f * f) >> WEIGHT_W;
      m  = (64'd3 << WEIGHT_W) - 64'd2 * f;
      return (sq * m) >> WEIGHT_W;
    endfunction

    // flooring lerp on offset-binary values
    function logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] t);
      return (a * ((64'd1 << WEIGHT_W) - t) + b * t) >> WEIGHT_W;
    endfunction

    function void split(input coord_t p, output logic [31:0] lo, output logic [31:0] hi,
                        output logic [63:0] w);
      logic [63:0] frac;
      logic [63:0] f;
      frac = 64'(p) & ((64'd1 << shift) - 64'd1);
      lo   = 32'(p >> shift);
      hi   = lo + ((frac != 0) ? 32'd1 : 32'd0);
      f    = frac << (WEIGHT_W - int'(shift));
      w    = smooth(f);
    endfunction

    function void note_pixel(coord_t x, coord_t y);
      logic [31:0] col_l, col_r, row_t, row_b;
      logic [63:0] tx, ty, lv, rv, v;
      split(x, col_l, col_r, tx);
      split(y, row_t, row_b, ty);
      lv = blend(64'(corner(col_l, row_t)), 64'(corner(col_l, row_b)), ty);
      rv = blend(64'(corner(col_r, row_t)), 64'(corner(col_r, row_b)), ty);
      v  = blend(lv, rv, tx);
      expected_noise.push_back(signed'(v[31:0] ^ SIGN_FLIP));
    endfunction

    function void check_noise(logic signed [NOISE_W-1:0] got);
      logic signed [NOISE_W-1:0] want;
      if (expected_noise.size() == 0) begin
        errors++;
        $display("%0t unexpected noise word: expected none actual %0d", $time, got);
      end else begin
        want = expected_noise.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t noise mismatch: expected %0d actual %0d", $time, want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  vn2d_pix_if   pix_if ();
  vn2d_noise_if noise_if ();
  vn2d_cfg_if   cfg_if ();

  value_noise_2d_sampler u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .pix_i   (pix_if),
    .noise_o (noise_if),
    .cfg_i   (cfg_if)
  );

  noise_predictor pred = new();

  bit hold_req;
  bit tx_burst;
  bit tx_hurry;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("value_noise_2d_sampler regression: fail");
    $finish;
  end

  task automatic send_pixel(input coord_t x, input coord_t y);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = (tx_burst || tx_hurry) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid   <= 1'b1;
    pix_if.pixel_x <= x;
    pix_if.pixel_y <= y;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    pred.note_pixel(x, y);
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    while (pred.expected_noise.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    pred.write_reg(idx, data);
  endtask

  task automatic configure(input hash_t seed_word, input logic [CFG_DATA_W-1:0] shift_word,
                           input bit do_junk, input logic [CFG_IDX_W-1:0] junk_idx);
    drain();
    write_reg(CFG_SEED, seed_word);
    write_reg(CFG_SCALE_SHIFT, shift_word);
    if (do_junk) write_reg(junk_idx, $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic coord_t pick_coord();
    coord_t v;
    v = coord_t'($urandom);
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = v & ~coord_t'((17'd1 << pred.shift) - 17'd1);
      3: v = v | coord_t'((17'd1 << pred.shift) - 17'd1);
      default: ;
    endcase
    return v;
  endfunction

  initial begin : noise_sink
    int  stall;
    bit  rx_burst;
    rx_burst = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        noise_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        stall = rx_burst ? 0 : $urandom_range(0, 18);
        if (stall > 0) begin
          noise_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      noise_if.ready <= 1'b1;
      @(posedge clk);
      while (!noise_if.valid) @(posedge clk);
      pred.check_noise(noise_if.noise_value);
    end
  end

  initial begin : stimulus
    hash_t             seed_word;
    logic [SHIFT_W-1:0] shift_val;
    hold_req        = 1'b0;
    tx_burst        = 1'b0;
    tx_hurry        = 1'b0;
    rst_n           = 1'b0;
    pix_if.valid    = 1'b0;
    pix_if.pixel_x  = '0;
    pix_if.pixel_y  = '0;
    noise_if.ready  = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero seed, every pixel on a lattice corner
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h0001, 16'h0002);

    // widest spacing, all-ones seed, zero and full fractions
    configure(32'hFFFF_FFFF, 32'h0000_000F, 1'b1, 8'hFF);
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h8000, 16'h8000);
    send_pixel(16'h8000, 16'h7FFF);
    send_pixel(16'h7FFF, 16'h0001);
    send_pixel(16'hFFFF, 16'h0000);

    // upper shift bits must be dropped: shift 8
    configure(32'h9E37_79B9, 32'hFFFF_FFF8, 1'b1, 8'h02);
    send_pixel(16'h1200, 16'h34FF);
    send_pixel(16'h12FF, 16'h3400);
    send_pixel(16'hFF00, 16'h00FF);
    send_pixel(16'h00FF, 16'hFF00);

    configure(32'h0000_0000, 32'h0000_0001, 1'b1, 8'h80);
    send_pixel(16'h0000, 16'h0001);
    send_pixel(16'h0001, 16'h0000);
    send_pixel(16'h0001, 16'h0001);
    send_pixel(16'hFFFF, 16'hFFFE);

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: seed_word = '0;
        1: seed_word = '1;
        default: seed_word = hash_t'($urandom);
      endcase
      if (ph == 0) shift_val = '0;
      else if (ph == 1) shift_val = '1;
      else shift_val = SHIFT_W'($urandom_range(0, 15));
      configure(seed_word, {28'($urandom), shift_val}, 1'($urandom),
                CFG_IDX_W'($urandom_range(2, 255)));
      if (ph == 3) begin
        hold_req = 1'b1;
        tx_hurry = 1'b1;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 5 && i == PHASE_WORDS / 2) drain();
        send_pixel(pick_coord(), pick_coord());
      end
      tx_hurry = 1'b0;
    end

    drain();
    repeat (20) @(posedge clk);
    if (pred.expected_noise.size() != 0)
      $display("%0t %0d noise words never arrived", $time, pred.expected_noise.size());
    if (pred.errors == 0 && pred.expected_noise.size() == 0) begin
      $display("value_noise_2d_sampler regression: pass");
    end else begin
      $display("value_noise_2d_sampler regression: fail");
    end
    $finish;
  end

endmodule
